// ===== sv/delay_line_pitch_shifter_assert.svh =====
// assertion macros for the delay line pitch shifter
// no dependencies; included by the modules that carry assertions
`ifndef DELAY_LINE_PITCH_SHIFTER_ASSERT_SVH
`define DELAY_LINE_PITCH_SHIFTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DLPS_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DLPS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dlps_pkg.sv =====
// shared constants, state and command types for the delay line pitch shifter
// no dependencies
package dlps_pkg;

    // field widths
    localparam int SAMPLE_W        = 24;
    localparam int RATIO_W         = 18;

    // fixed-point and store geometry
    localparam int PHASE_FRAC_BITS = 16;
    localparam int WINDOW_BITS     = 10;
    localparam int STORE_ADDR_W    = 11;
    localparam int STORE_DEPTH     = 1 << STORE_ADDR_W;
    localparam int PHASE_W         = WINDOW_BITS + PHASE_FRAC_BITS;
    localparam int POS_W           = STORE_ADDR_W + PHASE_FRAC_BITS;
    localparam int WEIGHT_W        = PHASE_FRAC_BITS + 1;

    // shared multiplier and accumulator widths
    localparam int DIFF_W          = SAMPLE_W + 1;
    localparam int MUL_A_W         = SAMPLE_W + 1;
    localparam int MUL_B_W         = WEIGHT_W + 1;
    localparam int PROD_W          = MUL_A_W + MUL_B_W;
    localparam int ACC_W           = PROD_W + 1;

    // ratio constants
    localparam int RATIO_ONE       = 65536;
    localparam int BYPASS_BAND     = 6;

    // output clamp
    localparam int SAT_MAX         = 8388607;
    localparam int SAT_MIN         = -8388608;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_M0,
        S_M1,
        S_M2,
        S_OUT
    } t_state;

    // datapath step commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_RD0,
        OP_RD1,
        OP_RD2,
        OP_RD3,
        OP_M0,
        OP_M1,
        OP_M2,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_out;
    } t_dp_cmd;

endpackage

// ===== sv/delay_line_pitch_shifter.sv =====
// two-tap delay line pitch shifter; one item at a time through a shared multiplier
// sequence: after the input transfer, four single-port store reads and four multiplies
// through one multiplier, then the output step loads the result shown on o_out_valid;
// a new item is taken only after the output step, which waits while a shown result stalls
// reset: synchronous active low; clears index, phases, ratio and handshake state,
// store entries not yet written read as zero, so there is no clearing pass
module delay_line_pitch_shifter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [dlps_pkg::SAMPLE_W-1:0] i_in_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [dlps_pkg::SAMPLE_W-1:0] o_out_sample,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic        [dlps_pkg::RATIO_W-1:0]  i_cfg_pitch_ratio
);

    dlps_pkg::t_dp_cmd cmd;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    dlps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // store and arithmetic
    dlps_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_pitch_ratio (i_cfg_pitch_ratio),
        .i_in_sample       (i_in_sample),
        .o_out_sample      (o_out_sample)
    );

endmodule

// ===== sv/dlps_dp.sv =====
// datapath: delay store, tap phases, interpolation, windowing and output register
// depends on dlps_pkg and delay_line_pitch_shifter_assert.svh
`include "delay_line_pitch_shifter_assert.svh"

module dlps_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  dlps_pkg::t_dp_cmd                     i_cmd,
    input  logic                                  i_cfg_valid,
    input  logic        [dlps_pkg::RATIO_W-1:0]   i_cfg_pitch_ratio,
    input  logic signed [dlps_pkg::SAMPLE_W-1:0]  i_in_sample,
    output logic signed [dlps_pkg::SAMPLE_W-1:0]  o_out_sample
);

    localparam int F      = dlps_pkg::PHASE_FRAC_BITS;
    localparam int SW     = dlps_pkg::SAMPLE_W;
    localparam int RW     = dlps_pkg::RATIO_W;
    localparam int PW     = dlps_pkg::PHASE_W;
    localparam int AW     = dlps_pkg::STORE_ADDR_W;
    localparam int POSW   = dlps_pkg::POS_W;
    localparam int WW     = dlps_pkg::WEIGHT_W;
    localparam int PRW    = dlps_pkg::PROD_W;
    localparam int ACW    = dlps_pkg::ACC_W;
    localparam int YW     = ACW - F;

    localparam logic        [RW-1:0]   RATIO_RESET = RW'(dlps_pkg::RATIO_ONE);
    localparam logic signed [RW:0]     BAND_HI     = (RW + 1)'(dlps_pkg::BYPASS_BAND);
    localparam logic signed [RW:0]     BAND_LO     = -BAND_HI;
    localparam logic        [PW-1:0]   HALF_WIN    = {1'b1, {(PW - 1){1'b0}}};
    localparam logic signed [PW+1:0]   WIN_S       = {2'b01, {PW{1'b0}}};
    localparam logic signed [YW-1:0]   Y_MAX       = YW'(dlps_pkg::SAT_MAX);
    localparam logic signed [YW-1:0]   Y_MIN       = YW'(dlps_pkg::SAT_MIN);
    localparam int                     ROUND       = 1 << (F - 1);

    // read position: write index minus delay, wrapping over the store
    function automatic logic [POSW-1:0] tap_pos(input logic [AW-1:0] wi,
                                                 input logic [PW-1:0] d);
        return {wi, {F{1'b0}}} - POSW'(d);
    endfunction

    // triangular window weight 1 - |2p/W - 1| with F fraction bits
    function automatic logic [WW-1:0] tri_weight(input logic [PW-1:0] p);
        logic signed [PW+1:0] d;
        logic        [PW:0]   mag;
        logic        [PW:0]   num;
        d   = $signed({1'b0, p, 1'b0}) - WIN_S;
        mag = d[PW+1] ? (PW + 1)'(-d) : (PW + 1)'(d);
        num = {1'b1, {PW{1'b0}}} - mag;
        return num[PW:dlps_pkg::WINDOW_BITS];
    endfunction

    // advance a phase by the step and wrap once into the window
    function automatic logic [PW-1:0] advance(input logic        [PW-1:0] p,
                                              input logic signed [RW:0]   step);
        logic signed [PW+1:0] s;
        s = $signed({2'b00, p}) + (PW + 2)'(step);
        if (s >= WIN_S) begin
            s = s - WIN_S;
        end else if (s < 0) begin
            s = s + WIN_S;
        end
        return s[PW-1:0];
    endfunction

    logic        [RW-1:0]  r_ratio;
    logic        [AW-1:0]  r_wi;
    logic                  r_full;
    logic        [PW-1:0]  r_phase1;
    logic        [PW-1:0]  r_phase2;
    logic                  r_bypass;
    logic        [AW-1:0]  r_idx1;
    logic        [AW-1:0]  r_idx2;
    logic        [F-1:0]   r_frac1;
    logic        [F-1:0]   r_frac2;
    logic        [WW-1:0]  r_w1;
    logic        [WW-1:0]  r_w2;
    logic        [SW-1:0]  mem [dlps_pkg::STORE_DEPTH];
    logic        [SW-1:0]  r_rdata;
    logic                  r_rd_ok;
    logic signed [SW-1:0]  r_s0;
    logic signed [PRW-1:0] r_base;
    logic signed [PRW-1:0] r_prod;
    logic signed [PRW-1:0] r_acc;
    logic signed [SW-1:0]  r_r1;
    logic signed [SW-1:0]  r_r2;
    logic signed [SW-1:0]  r_out;

    logic        [AW-1:0]             wi_next;
    logic signed [RW:0]               step;
    logic                             bypass;
    logic        [PW-1:0]             d1;
    logic        [POSW-1:0]           pos1;
    logic        [POSW-1:0]           pos2;
    logic                             accept;
    logic        [AW-1:0]             rd_addr;
    logic signed [SW-1:0]             rdata_eff;
    logic signed [dlps_pkg::DIFF_W-1:0]  diff;
    logic signed [dlps_pkg::MUL_A_W-1:0] mul_a;
    logic signed [dlps_pkg::MUL_B_W-1:0] mul_b;
    logic                             mul_en;
    logic signed [PRW-1:0]            base_next;
    logic signed [PRW-1:0]            interp_sum;
    logic signed [SW-1:0]             interp;
    logic signed [ACW-1:0]            out_sum;
    logic signed [YW-1:0]             y_full;
    logic signed [SW-1:0]             y_sat;

    // per-item setup from the register and the current phases
    assign accept  = (i_cmd.op == dlps_pkg::OP_ACCEPT);
    assign wi_next = r_wi + 1'b1;
    assign step    = $signed({1'b0, RATIO_RESET}) - $signed({1'b0, r_ratio});
    assign bypass  = (step >= BAND_LO) && (step <= BAND_HI);
    assign d1      = bypass ? HALF_WIN : r_phase1;
    assign pos1    = tap_pos(wi_next, d1);
    assign pos2    = tap_pos(wi_next, r_phase2);

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_RESET;
        end else if (i_cfg_valid) begin
            r_ratio <= i_cfg_pitch_ratio;
        end
    end

    // write index, fill flag and tap phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi     <= '0;
            r_full   <= 1'b0;
            r_phase1 <= '0;
            r_phase2 <= HALF_WIN;
        end else if (accept) begin
            r_wi   <= wi_next;
            r_full <= r_full | (r_wi == {AW{1'b1}});
            if (!bypass) begin
                r_phase1 <= advance(r_phase1, step);
                r_phase2 <= advance(r_phase2, step);
            end
        end
    end

    // latched tap positions and weights for the item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bypass <= bypass;
            r_idx1   <= pos1[POSW-1:F];
            r_frac1  <= pos1[F-1:0];
            r_idx2   <= pos2[POSW-1:F];
            r_frac2  <= pos2[F-1:0];
            r_w1     <= tri_weight(r_phase1);
            r_w2     <= tri_weight(r_phase2);
        end
    end

    // read address per step
    always_comb begin
        unique case (i_cmd.op)
            dlps_pkg::OP_RD0: rd_addr = r_idx1;
            dlps_pkg::OP_RD1: rd_addr = r_idx1 + 1'b1;
            dlps_pkg::OP_RD2: rd_addr = r_idx2;
            dlps_pkg::OP_RD3: rd_addr = r_idx2 + 1'b1;
            default:          rd_addr = r_idx1;
        endcase
    end

    // delay store, registered read; entries not yet written read as zero
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem[r_wi] <= i_in_sample;
        end
        r_rdata <= mem[rd_addr];
        r_rd_ok <= r_full || (rd_addr < r_wi);
    end

    assign rdata_eff = r_rd_ok ? $signed(r_rdata) : '0;
    assign diff      = dlps_pkg::DIFF_W'(rdata_eff) - dlps_pkg::DIFF_W'(r_s0);
    assign base_next = (PRW'(r_s0) <<< F) + PRW'(ROUND);

    // shared multiplier operand select
    always_comb begin
        mul_en = 1'b1;
        case (i_cmd.op)
            dlps_pkg::OP_RD2: begin
                mul_a = diff;
                mul_b = $signed({2'b00, r_frac1});
            end
            dlps_pkg::OP_M0: begin
                mul_a = diff;
                mul_b = $signed({2'b00, r_frac2});
            end
            dlps_pkg::OP_M1: begin
                mul_a = dlps_pkg::MUL_A_W'(r_r1);
                mul_b = $signed({1'b0, r_w1});
            end
            dlps_pkg::OP_M2: begin
                mul_a = dlps_pkg::MUL_A_W'(r_r2);
                mul_b = $signed({1'b0, r_w2});
            end
            default: begin
                mul_en = 1'b0;
                mul_a  = diff;
                mul_b  = $signed({2'b00, r_frac1});
            end
        endcase
    end

    // interpolation result, rounded half up
    assign interp_sum = r_base + r_prod;
    assign interp     = interp_sum[F+SW-1:F];

    // windowed sum, rounded and clamped
    assign out_sum = ACW'(r_acc) + ACW'(r_prod) + ACW'(ROUND);
    assign y_full  = out_sum[ACW-1:F];
    always_comb begin
        if (y_full > Y_MAX) begin
            y_sat = SW'(Y_MAX);
        end else if (y_full < Y_MIN) begin
            y_sat = SW'(Y_MIN);
        end else begin
            y_sat = y_full[SW-1:0];
        end
    end

    // arithmetic pipeline registers
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.op == dlps_pkg::OP_RD1 || i_cmd.op == dlps_pkg::OP_RD3) begin
            r_s0 <= rdata_eff;
        end
        if (i_cmd.op == dlps_pkg::OP_RD2 || i_cmd.op == dlps_pkg::OP_M0) begin
            r_base <= base_next;
        end
        if (i_cmd.op == dlps_pkg::OP_RD3) begin
            r_r1 <= interp;
        end
        if (i_cmd.op == dlps_pkg::OP_M1) begin
            r_r2 <= interp;
        end
        if (i_cmd.op == dlps_pkg::OP_M2) begin
            r_acc <= r_prod;
        end
        if (i_cmd.load_out) begin
            r_out <= r_bypass ? r_r1 : y_sat;
        end
    end

    assign o_out_sample = r_out;

    // phases hold across a transfer in the bypass band
    `DLPS_ASSERT_NEXT(a_bypass_phase_hold, i_clk, i_rst_n, accept && bypass, $stable(r_phase1) && $stable(r_phase2), "phase moved in bypass")

endmodule

// ===== sv/dlps_ctrl.sv =====
// controller: sequences one item through writes, reads, multiplies and output
// depends on dlps_pkg and delay_line_pitch_shifter_assert.svh
`include "delay_line_pitch_shifter_assert.svh"

module dlps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output dlps_pkg::t_dp_cmd o_cmd
);

    dlps_pkg::t_state r_state;
    dlps_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dlps_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state        = r_state;
        o_cmd.op       = dlps_pkg::OP_NONE;
        o_cmd.load_out = 1'b0;
        o_in_stall     = 1'b1;
        unique case (r_state)
            dlps_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = dlps_pkg::OP_ACCEPT;
                    n_state  = dlps_pkg::S_RD0;
                end
            end
            dlps_pkg::S_RD0: begin
                o_cmd.op = dlps_pkg::OP_RD0;
                n_state  = dlps_pkg::S_RD1;
            end
            dlps_pkg::S_RD1: begin
                o_cmd.op = dlps_pkg::OP_RD1;
                n_state  = dlps_pkg::S_RD2;
            end
            dlps_pkg::S_RD2: begin
                o_cmd.op = dlps_pkg::OP_RD2;
                n_state  = dlps_pkg::S_RD3;
            end
            dlps_pkg::S_RD3: begin
                o_cmd.op = dlps_pkg::OP_RD3;
                n_state  = dlps_pkg::S_M0;
            end
            dlps_pkg::S_M0: begin
                o_cmd.op = dlps_pkg::OP_M0;
                n_state  = dlps_pkg::S_M1;
            end
            dlps_pkg::S_M1: begin
                o_cmd.op = dlps_pkg::OP_M1;
                n_state  = dlps_pkg::S_M2;
            end
            dlps_pkg::S_M2: begin
                o_cmd.op = dlps_pkg::OP_M2;
                n_state  = dlps_pkg::S_OUT;
            end
            dlps_pkg::S_OUT: begin
                o_cmd.op = dlps_pkg::OP_OUT;
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = dlps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dlps_pkg::S_IDLE;
            end
        endcase
    end

    // result stays until the downstream transfer
    assign n_out_valid = o_cmd.load_out | (r_out_valid & i_out_stall);
    assign o_out_valid = r_out_valid;

    `DLPS_ASSERT_NEXT(a_accept_starts_reads, i_clk, i_rst_n, (r_state == dlps_pkg::S_IDLE) && i_in_valid, r_state == dlps_pkg::S_RD0, "transfer did not start reads")
    `DLPS_ASSERT_NEXT(a_out_wait_holds, i_clk, i_rst_n, (r_state == dlps_pkg::S_OUT) && r_out_valid && i_out_stall, r_state == dlps_pkg::S_OUT, "left output step with result pending")
    `DLPS_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, o_cmd.load_out, o_out_valid, "loaded result not shown")

endmodule
